FILE: rtl/core/wbps_pkg.sv
// Package: shared constants, register indexes and types for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_OFFSET_BITS       = 32;

    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 48;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int MASK_W      = 16;
    localparam int LEN_W       = 5;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_REGION_BASE  = 3'd4
    } cfg_reg_t;

    // one result transaction
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } result_t;

endpackage

FILE: rtl/core/wildcard_byte_pattern_scanner_top.sv
// Top level: wildcard byte pattern scanner with config write port and two-deep result queue.
`timescale 1ns / 1ps

// Output: a result is registered into the head of the result queue, or into the skid slot while the head is stalled.
// Throughput: one byte per cycle; compare, position update and address add are done in the same cycle.
// Input stalls only while two results wait unread in the output queue.
// Reset (rst_n low, asynchronous) clears scan state, queue and config registers
// (pattern length resets to 1, all others to 0).
module wildcard_byte_pattern_scanner_top #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = wbps_pkg::DEF_OFFSET_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data,

    // byte stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wbps_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte

    // results out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wbps_pkg::ADDR_W-1:0]        m_tdata,   // [47:0] match_address
    output logic                               m_tuser    // [0] found
);

    import wbps_pkg::*;

    localparam int POS_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [MASK_W-1:0]     wildcard_reg;
    logic [LEN_W-1:0]      pattern_len_reg;
    logic [ADDR_W-1:0]     region_base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            wildcard_reg     <= '0;
            pattern_len_reg  <= LEN_RESET;
            region_base_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_WILDCARD:     wildcard_reg     <= cfg_data[MASK_W-1:0];
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LEN_W-1:0];
                REG_REGION_BASE:  region_base_reg  <= cfg_data[ADDR_W-1:0];
                default:          ; // unknown index: write dropped
            endcase
        end
    end

    // ---------------- scan state ----------------
    logic [POS_BITS-1:0]    pos_reg,    pos_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] first_reg,  first_next;
    logic                   done_reg,   done_next;

    logic                   in_fire;
    logic                   emit;
    result_t                emit_res;

    logic [2*CFG_DATA_W-1:0] pattern_all;
    logic [PAT_IDX_W-1:0]    pat_idx;
    logic [BYTE_W-1:0]       pat_byte;
    logic                    wild;
    logic                    hit;
    logic [LEN_W-1:0]        eff_len;
    logic [LEN_W-1:0]        pos_plus;
    logic [OFFSET_BITS-1:0]  first_cand;

    assign in_fire     = s_tvalid && s_tready;
    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign pat_idx     = PAT_IDX_W'(pos_reg);
    assign pat_byte    = pattern_all[{pat_idx, 3'b000} +: BYTE_W];
    assign wild        = wildcard_reg[pat_idx];
    assign hit         = wild || (s_tdata == pat_byte);
    assign pos_plus    = LEN_W'(pos_reg) + LEN_W'(1);

    // clamp the programmed length into 1..MAX_PATTERN_BYTES
    always_comb
    begin
        if (pattern_len_reg == '0)
            eff_len = LEN_W'(1);
        else if (pattern_len_reg > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = pattern_len_reg;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        offset_next = offset_reg;
        first_next  = first_reg;
        done_next   = done_reg;
        emit        = 1'b0;
        emit_res    = '0;
        first_cand  = (pos_reg == '0) ? offset_reg : first_reg;

        if (in_fire)
        begin
            if (!done_reg)
            begin
                if (hit)
                begin
                    first_next = first_cand;
                    if (pos_plus >= eff_len)
                    begin
                        // whole pattern matched: report start address
                        done_next     = 1'b1;
                        pos_next      = '0;
                        emit          = 1'b1;
                        emit_res.found = 1'b1;
                        emit_res.addr  = region_base_reg + ADDR_W'(first_cand);
                    end
                    else
                    begin
                        pos_next = POS_BITS'(pos_plus);
                    end
                end
                else
                begin
                    // naive restart: failing byte not retried at position 0
                    pos_next   = '0;
                    first_next = '0;
                end
            end

            offset_next = offset_reg + OFFSET_BITS'(1);

            if (s_tlast)
            begin
                if (!done_next)
                begin
                    emit     = 1'b1;
                    emit_res = '0;   // not found
                end
                pos_next    = '0;
                offset_next = '0;
                first_next  = '0;
                done_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            offset_reg <= '0;
            first_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            first_reg  <= first_next;
            done_reg   <= done_next;
        end
    end

    // ---------------- two-deep result queue ----------------
    // head drives the port; skid catches a result while head is stalled
    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_reg,       head_next;
    result_t skid_reg,       skid_next;
    logic    pop;

    assign pop      = head_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_reg.addr;
    assign m_tuser  = head_reg.found;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;

        if (head_valid_reg && !pop)
        begin
            // head stalled; skid is empty whenever a byte was taken
            if (emit)
            begin
                skid_valid_next = 1'b1;
                skid_next       = emit_res;
            end
        end
        else if (skid_valid_reg)
        begin
            head_valid_next = 1'b1;
            head_next       = skid_reg;
            skid_valid_next = emit;
            skid_next       = emit_res;
        end
        else
        begin
            head_valid_next = emit;
            head_next       = emit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: tb/sv/tb_wildcard_byte_pattern_scanner_top.sv
// Testbench: wildcard byte pattern scanner, checked transaction by transaction against a predictor.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_top;

    import wbps_pkg::*;

    // Roughly 15 percent of the time idle on each side, except in the calm phase.
    localparam int IDLE_PCT      = 15;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_BYTES   = 155;
    // Cycles to let pass after the last expected result.
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } scan_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;   // [7:0] data_byte
    logic                   s_tlast = 1'b0; // last_byte

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [ADDR_W-1:0]      m_tdata;        // [47:0] match_address
    logic                   m_tuser;        // [0] found

    // Bytes waiting to go out, and results the scanner owes us, oldest first.
    scan_item_t             byte_queue[$];
    result_t                due_results[$];

    // Predictor copy of the configuration registers.
    logic [CFG_DATA_W-1:0]  pat_lo;
    logic [CFG_DATA_W-1:0]  pat_hi;
    logic [MASK_W-1:0]      wild_mask;
    logic [LEN_W-1:0]       pat_len;
    logic [ADDR_W-1:0]      region_base;

    // Predictor copy of the scan state.
    logic [LEN_W-1:0]           scan_pos;
    logic [DEF_OFFSET_BITS-1:0] scan_offset;
    logic [DEF_OFFSET_BITS-1:0] start_offset;
    logic                       scan_done;

    bit                     calm = 1'b0;
    int                     bytes_pushed = 0;
    int                     bytes_taken = 0;
    int                     results_seen = 0;
    int                     matches_seen = 0;
    int                     mismatches = 0;
    int                     phase_start;

    wildcard_byte_pattern_scanner_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Out-of-range lengths: 0 behaves as 1, anything past 16 as 16.
    function automatic logic [LEN_W-1:0] used_length();
        if (pat_len == '0)
            return LEN_W'(1);
        if (pat_len > LEN_W'(PAT_BYTES))
            return LEN_W'(PAT_BYTES);
        return pat_len;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_at(input logic [PAT_IDX_W-1:0] pos);
        logic [CFG_DATA_W-1:0] word;
        word = pos[3] ? pat_hi : pat_lo;
        return word[pos[2:0]*8 +: 8];
    endfunction

    // A byte that matches pattern position i, random where i is a wildcard.
    function automatic logic [BYTE_W-1:0] matching_byte(input int i);
        return wild_mask[i] ? BYTE_W'($urandom) : pattern_at(PAT_IDX_W'(i));
    endfunction

    // Advance the predicted scan by one accepted byte; queue the result it causes, if any.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [PAT_IDX_W-1:0] pos;
        result_t              res;
        if (!scan_done)
        begin
            pos = scan_pos[PAT_IDX_W-1:0];
            if (wild_mask[pos] || b == pattern_at(pos))
            begin
                if (pos == '0)
                    start_offset = scan_offset;
                // position at or past the last one in use closes the match
                if ({1'b0, pos} + LEN_W'(1) >= used_length())
                begin
                    scan_done = 1'b1;
                    scan_pos  = '0;
                    res.found = 1'b1;
                    res.addr  = region_base + ADDR_W'(start_offset);
                    due_results.push_back(res);
                end
                else
                begin
                    scan_pos = {1'b0, pos} + LEN_W'(1);
                end
            end
            else
            begin
                // naive restart: the failing byte is not retried at position 0
                scan_pos     = '0;
                start_offset = '0;
            end
        end
        scan_offset = scan_offset + DEF_OFFSET_BITS'(1);
        if (last)
        begin
            if (!scan_done)
            begin
                res.found = 1'b0;
                res.addr  = '0;
                due_results.push_back(res);
            end
            scan_pos     = '0;
            scan_offset  = '0;
            start_offset = '0;
            scan_done    = 1'b0;
        end
    endtask

    // Stream driver: holds each transaction until accepted, idles at random between them.
    always @(posedge clk)
    begin : drive_bytes
        scan_item_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted transaction with the oldest prediction.
    always @(posedge clk)
    begin : watch_results
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual found=%0b addr=%h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.found)
                        matches_seen++;
                    if (m_tuser !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want.found, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== want.addr)
                    begin
                        $display("%0t: match_address mismatch, expected %h, actual %h",
                                 $time, want.addr, m_tdata);
                        mismatches++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // One register write on the config channel; the predictor copy follows on acceptance.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:  pat_lo      = val;
            REG_PATTERN_HIGH: pat_hi      = val;
            REG_WILDCARD:     wild_mask   = val[MASK_W-1:0];
            REG_PATTERN_LEN:  pat_len     = val[LEN_W-1:0];
            REG_REGION_BASE:  region_base = val[ADDR_W-1:0];
            default: ;  // unused index, scanner ignores it
        endcase
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        scan_item_t it;
        it.data = b;
        it.last = last;
        byte_queue.push_back(it);
        bytes_pushed++;
    endtask

    // Sender stops until every byte is taken and every result is back, then lets it settle.
    task automatic wait_scanner_idle();
        while (byte_queue.size() != 0 || bytes_taken != bytes_pushed ||
               due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A region built from pattern copies, broken runs and noise; open-ended if !close.
    task automatic push_region(input bit close);
        int                len;
        int                segs;
        int                pick;
        int                n;
        logic [BYTE_W-1:0] bytes[$];
        len  = int'(used_length());
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                for (int i = 0; i < len; i++)
                    bytes.push_back(matching_byte(i));
            end
            else if (pick < 70)
            begin
                n = $urandom_range(0, len - 1);
                for (int i = 0; i < n; i++)
                    bytes.push_back(matching_byte(i));
                bytes.push_back(BYTE_W'($urandom));
            end
            else
            begin
                // noise drawn half from the pattern's own bytes to provoke false starts
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    bytes.push_back($urandom_range(1) ? BYTE_W'($urandom)
                                                      : pattern_at(PAT_IDX_W'($urandom)));
            end
        end
        foreach (bytes[i])
            push_byte(bytes[i], close && (i == bytes.size() - 1));
    endtask

    // Stimulus: reset, directed cases, then randomized config phases.
    initial
    begin : stimulus
        logic [LEN_W-1:0] len_pick;
        pat_lo      = '0;
        pat_hi      = '0;
        wild_mask   = '0;
        pat_len     = LEN_RESET;
        region_base = '0;
        scan_pos     = '0;
        scan_offset  = '0;
        start_offset = '0;
        scan_done    = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: pattern 41 42 ?? 44, base off zero
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_4400_4241);
        write_reg(REG_PATTERN_HIGH, 64'hFFEE_DDCC_BBAA_9988);
        write_reg(REG_WILDCARD, CFG_DATA_W'(16'h0004));
        write_reg(REG_PATTERN_LEN, CFG_DATA_W'(4));
        write_reg(REG_REGION_BASE, CFG_DATA_W'(48'h0000_1234_5000));
        // writes to unused indexes must leave the registers alone
        for (int k = int'(REG_REGION_BASE) + 1; k < (1 << CFG_INDEX_W); k++)
            write_reg(CFG_INDEX_W'(k), '1);

        // plain hit, then the tail of the region is ignored
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h44, 1'b0);
        push_byte(8'h5A, 1'b1);
        // repeated first byte: naive restart loses the real match -> not found
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h44, 1'b1);
        // match completing on the final byte: found only
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h44, 1'b1);
        // one-byte region, no match
        push_byte(8'h00, 1'b1);
        // partial match left open, then length cut to the current position
        push_byte(8'h13, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        wait_scanner_idle();
        write_reg(REG_PATTERN_LEN, CFG_DATA_W'(2));
        push_byte(8'h99, 1'b0);
        push_byte(8'h5A, 1'b1);
        wait_scanner_idle();
        // zero length acts as one
        write_reg(REG_PATTERN_LEN, CFG_DATA_W'(0));
        push_byte(8'h80, 1'b0);
        push_byte(8'h41, 1'b1);
        wait_scanner_idle();

        // Random phases: new config each time, some regions left open across the change
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // all-ones pattern and base: address add wraps past 2^48
                    write_reg(REG_PATTERN_LOW, '1);
                    write_reg(REG_PATTERN_HIGH, '1);
                    write_reg(REG_WILDCARD, '0);
                    write_reg(REG_PATTERN_LEN, CFG_DATA_W'(PAT_BYTES));
                    write_reg(REG_REGION_BASE, CFG_DATA_W'({ADDR_W{1'b1}}));
                end
                1:
                begin
                    write_reg(REG_PATTERN_LOW, '0);
                    write_reg(REG_PATTERN_HIGH, '0);
                    write_reg(REG_WILDCARD, '0);
                    write_reg(REG_PATTERN_LEN, CFG_DATA_W'(1));
                    write_reg(REG_REGION_BASE, '0);
                end
                2:
                begin
                    // every position a wildcard
                    write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
                    write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
                    write_reg(REG_WILDCARD, CFG_DATA_W'({MASK_W{1'b1}}));
                    write_reg(REG_PATTERN_LEN, CFG_DATA_W'(PAT_BYTES));
                    write_reg(REG_REGION_BASE, CFG_DATA_W'(ADDR_W'({$urandom, $urandom})));
                end
                default:
                begin
                    case ($urandom_range(9))
                        0:       len_pick = '0;
                        1:       len_pick = LEN_W'($urandom_range(PAT_BYTES + 1, 31));
                        default: len_pick = LEN_W'($urandom_range(1, PAT_BYTES));
                    endcase
                    write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
                    write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
                    write_reg(REG_WILDCARD, CFG_DATA_W'(MASK_W'($urandom & $urandom)));
                    write_reg(REG_PATTERN_LEN, CFG_DATA_W'(len_pick));
                    write_reg(REG_REGION_BASE, CFG_DATA_W'(ADDR_W'({$urandom, $urandom})));
                end
            endcase

            // one phase runs both sides flat out
            calm = (p == 4);
            phase_start = bytes_pushed;
            while (bytes_pushed - phase_start < PHASE_BYTES)
            begin
                push_region(1'b1);
                // hold off until the queue runs dry now and then, so the sender goes quiet
                if (!calm && $urandom_range(15) == 0)
                    wait_scanner_idle();
            end
            push_region($urandom_range(1));
            wait_scanner_idle();
            calm = 1'b0;
        end

        // close any region still open from the last phase
        push_byte(BYTE_W'($urandom), 1'b1);
        wait_scanner_idle();

        $display("Run covered %0d bytes in %0d config phases plus directed cases.",
                 bytes_taken, NUM_PHASES);
        $display("Results checked: %0d (%0d found, %0d not found).",
                 results_seen, matches_seen, results_seen - matches_seen);
        if (mismatches == 0 && due_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d results still expected", due_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
